>>> sv/pf_pkg.sv
// playfair encryptor package: constants, codes, shared types and letter helpers
// no dependencies; imported by pf_ctrl, pf_obuf and the top level
package pf_pkg;

    localparam int LETTER_COUNT = 26;
    localparam int GRID_CELLS   = 25;

    typedef logic [4:0] letter_t;
    typedef logic [4:0] cell_t;
    typedef logic [2:0] coord_t;

    localparam letter_t IDX_I        = 5'd8;
    localparam letter_t IDX_J        = 5'd9;
    localparam letter_t IDX_X        = 5'd23;
    localparam letter_t IDX_LAST     = 5'd25;
    localparam cell_t   CELL_FULL    = 5'd25;
    localparam coord_t  COORD_LAST   = 3'd4;
    localparam logic [6:0] FILLER_RESET = 7'd88;
    localparam logic [6:0] ASCII_A      = 7'd65;

    typedef enum logic [2:0] {
        FN_KEY_START = 3'd0,
        FN_KEY_BYTE  = 3'd1,
        FN_KEY_DONE  = 3'd2,
        FN_TEXT      = 3'd3,
        FN_MSG_END   = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CELL,
        ST_EMIT,
        ST_SWEEP
    } state_t;

    typedef struct packed {
        logic    ok;
        letter_t letter;
    } lookup_t;

    // grid[slot] = letter and pos[letter] = slot in the same cycle
    typedef struct packed {
        logic    en;
        cell_t   slot;
        letter_t letter;
    } mem_wr_t;

    typedef struct packed {
        letter_t a;
        letter_t b;
        logic    done;
    } pair_t;

    function automatic lookup_t letter_of(logic [7:0] c);
        lookup_t    r;
        logic [7:0] d;
        r.ok = 1'b0;
        d    = '0;
        if (c >= 8'd65 && c <= 8'd90)
        begin
            r.ok = 1'b1;
            d    = c - 8'd65;
        end
        else if (c >= 8'd97 && c <= 8'd122)
        begin
            r.ok = 1'b1;
            d    = c - 8'd97;
        end
        r.letter = d[4:0];
        if (r.letter == IDX_J)
        begin
            r.letter = IDX_I;
        end
        return r;
    endfunction

    function automatic letter_t filler_for(logic [6:0] f, letter_t prev);
        letter_t    idx;
        logic [6:0] d;
        d   = f - ASCII_A;
        idx = (f >= 7'd65 && f <= 7'd90) ? d[4:0] : IDX_X;
        if (idx == IDX_J)
        begin
            idx = IDX_I;
        end
        if (idx == prev)
        begin
            idx = (idx == IDX_LAST) ? 5'd0 : idx + 5'd1;
            if (idx == IDX_J)
            begin
                idx = IDX_J + 5'd1;
            end
        end
        return idx;
    endfunction

    function automatic coord_t cell_row(cell_t p);
        coord_t r;
        if (p >= 5'd20)      r = 3'd4;
        else if (p >= 5'd15) r = 3'd3;
        else if (p >= 5'd10) r = 3'd2;
        else if (p >= 5'd5)  r = 3'd1;
        else                 r = 3'd0;
        return r;
    endfunction

    function automatic coord_t cell_col(cell_t p);
        cell_t base;
        cell_t diff;
        coord_t r;
        r    = cell_row(p);
        base = {r[2:0], 2'b00} + {2'b00, r};
        diff = p - base;
        return diff[2:0];
    endfunction

    function automatic coord_t coord_next(coord_t c);
        return (c >= COORD_LAST) ? 3'd0 : c + 3'd1;
    endfunction

    function automatic cell_t cell_of(coord_t r, coord_t c);
        return {r[2:0], 2'b00} + {2'b00, r} + {2'b00, c};
    endfunction

endpackage

>>> sv/pf_cmd_if.sv
// command channel: key and plaintext bytes with their function code
// no dependencies
interface pf_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] func;
    logic [7:0] ch;

    modport source (output valid, output func, output ch, input ready);
    modport sink   (input valid, input func, input ch, output ready);
endinterface

>>> sv/pf_cipher_if.sv
// cipher channel: one cipher letter per item with pair and message flags
// no dependencies
interface pf_cipher_if;
    logic       valid;
    logic       ready;
    logic [6:0] cipher_char;
    logic       last_of_pair;
    logic       message_done;

    modport source (output valid, output cipher_char, output last_of_pair,
                    output message_done, input ready);
    modport sink   (input valid, input cipher_char, input last_of_pair,
                    input message_done, output ready);
endinterface

>>> sv/pf_cfg_if.sv
// configuration write channel for the filler letter register
// no dependencies
interface pf_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] filler_letter;

    modport source (output valid, output filler_letter, input ready);
    modport sink   (input valid, input filler_letter, output ready);
endinterface

>>> sv/pf_ram.sv
// generic synchronous ram: one write port, two registered read ports
// no dependencies
module pf_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 26,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr0,
    input  logic [AW-1:0]    raddr1,
    output logic [WIDTH-1:0] rdata0,
    output logic [WIDTH-1:0] rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata0 <= mem[raddr0];
            rdata1 <= mem[raddr1];
        end
    end

endmodule

>>> sv/pf_obuf.sv
// output buffer: holds one cipher pair and hands it out as two letters
// depends on pf_pkg and pf_cipher_if
module pf_obuf (
    input  logic            clk,
    input  logic            rst_n,
    input  pf_pkg::pair_t   pair,
    input  logic            push,
    output logic            can_push,
    pf_cipher_if.source     cipher
);
    import pf_pkg::*;

    logic    valid_reg;
    logic    second_reg;
    letter_t a_reg;
    letter_t b_reg;
    logic    done_reg;
    letter_t shown;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end
        else if (push)
        begin
            valid_reg  <= 1'b1;
            second_reg <= 1'b0;
        end
        else if (cipher.valid && cipher.ready)
        begin
            if (second_reg)
            begin
                valid_reg  <= 1'b0;
                second_reg <= 1'b0;
            end
            else
            begin
                second_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            a_reg    <= pair.a;
            b_reg    <= pair.b;
            done_reg <= pair.done;
        end
    end

    assign can_push            = !valid_reg;
    assign shown               = second_reg ? b_reg : a_reg;
    assign cipher.valid        = valid_reg;
    assign cipher.cipher_char  = ASCII_A + {2'b00, shown};
    assign cipher.last_of_pair = second_reg;
    assign cipher.message_done = second_reg && done_reg;

endmodule

>>> sv/pf_ctrl.sv
// sequencer: key placement, grid completion sweep, pairing and lookup control
// depends on pf_pkg, pf_cmd_if and pf_cfg_if; drives the grid and position rams
module pf_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    pf_cmd_if.sink           cmd,
    pf_cfg_if.sink           cfg,
    output pf_pkg::mem_wr_t  mem_wr,
    output logic             pos_re,
    output pf_pkg::letter_t  pos_ra0,
    output pf_pkg::letter_t  pos_ra1,
    input  pf_pkg::cell_t    pos_rd0,
    input  pf_pkg::cell_t    pos_rd1,
    output logic             grid_re,
    output pf_pkg::cell_t    grid_ra0,
    output pf_pkg::cell_t    grid_ra1,
    input  pf_pkg::letter_t  grid_rd0,
    input  pf_pkg::letter_t  grid_rd1,
    output pf_pkg::pair_t    pair,
    output logic             push,
    input  logic             can_push
);
    import pf_pkg::*;

    state_t      state_reg, state_next;
    logic [25:0] used_reg, used_next;
    cell_t       count_reg, count_next;
    letter_t     pend_reg, pend_next;
    logic        pv_reg, pv_next;
    logic [6:0]  filler_reg;
    letter_t     sweep_reg, sweep_next;
    logic        done_reg, done_next;

    logic    accept;
    func_t   func;
    lookup_t lk;
    letter_t filler_pend;
    letter_t pair_b;
    logic    emit;
    logic    key_place;
    logic    sweep_place;
    coord_t  r1, c1, r2, c2;

    assign accept      = cmd.valid && cmd.ready;
    assign func        = func_t'(cmd.func);
    assign lk          = letter_of(cmd.ch);
    assign filler_pend = filler_for(filler_reg, pend_reg);
    // second letter is the text letter unless it repeats the held one or the message ends
    assign pair_b      = (func == FN_TEXT && lk.letter != pend_reg) ? lk.letter : filler_pend;

    assign emit = accept && pv_reg &&
                  ((func == FN_TEXT && lk.ok) || func == FN_MSG_END);
    assign key_place = accept && func == FN_KEY_BYTE && lk.ok &&
                       count_reg < CELL_FULL && !used_reg[lk.letter];
    assign sweep_place = state_reg == ST_SWEEP && sweep_reg != IDX_J &&
                         count_reg < CELL_FULL && !used_reg[sweep_reg];

    // datapath register updates
    always_comb
    begin
        used_next  = used_reg;
        count_next = count_reg;
        pend_next  = pend_reg;
        pv_next    = pv_reg;
        sweep_next = sweep_reg;
        done_next  = done_reg;
        if (accept)
        begin
            unique case (func)
                FN_KEY_START:
                begin
                    used_next  = '0;
                    count_next = '0;
                    pend_next  = '0;
                    pv_next    = 1'b0;
                end
                FN_KEY_BYTE:
                begin
                    if (key_place)
                    begin
                        used_next[lk.letter] = 1'b1;
                        count_next           = count_reg + 5'd1;
                    end
                end
                FN_KEY_DONE:
                begin
                    sweep_next = '0;
                end
                FN_TEXT:
                begin
                    if (lk.ok)
                    begin
                        if (!pv_reg)
                        begin
                            pend_next = lk.letter;
                            pv_next   = 1'b1;
                        end
                        else
                        begin
                            done_next = 1'b0;
                            if (lk.letter != pend_reg)
                            begin
                                pv_next = 1'b0;
                            end
                        end
                    end
                end
                FN_MSG_END:
                begin
                    if (pv_reg)
                    begin
                        done_next = 1'b1;
                        pv_next   = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (state_reg == ST_SWEEP)
        begin
            if (sweep_place)
            begin
                used_next[sweep_reg] = 1'b1;
                count_next           = count_reg + 5'd1;
            end
            sweep_next = sweep_reg + 5'd1;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (emit)
                begin
                    state_next = ST_CELL;
                end
                else if (accept && func == FN_KEY_DONE)
                begin
                    state_next = ST_SWEEP;
                end
            end
            ST_CELL:  state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (can_push)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SWEEP:
            begin
                if (sweep_reg == IDX_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // row, column and rectangle rules on the looked-up positions
    always_comb
    begin
        r1 = cell_row(pos_rd0);
        c1 = cell_col(pos_rd0);
        r2 = cell_row(pos_rd1);
        c2 = cell_col(pos_rd1);
        priority if (r1 == r2)
        begin
            grid_ra0 = cell_of(r1, coord_next(c1));
            grid_ra1 = cell_of(r2, coord_next(c2));
        end
        else if (c1 == c2)
        begin
            grid_ra0 = cell_of(coord_next(r1), c1);
            grid_ra1 = cell_of(coord_next(r2), c2);
        end
        else
        begin
            grid_ra0 = cell_of(r1, c2);
            grid_ra1 = cell_of(r2, c1);
        end
    end

    // outputs
    always_comb
    begin
        cmd.ready     = state_reg == ST_IDLE;
        cfg.ready     = 1'b1;
        mem_wr.en     = key_place || sweep_place;
        mem_wr.slot   = count_reg;
        mem_wr.letter = (state_reg == ST_SWEEP) ? sweep_reg : lk.letter;
        pos_re        = emit;
        pos_ra0       = pend_reg;
        pos_ra1       = pair_b;
        grid_re       = state_reg == ST_CELL;
        push          = state_reg == ST_EMIT && can_push;
        pair.a        = grid_rd0;
        pair.b        = grid_rd1;
        pair.done     = done_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            used_reg   <= '0;
            count_reg  <= '0;
            pend_reg   <= '0;
            pv_reg     <= 1'b0;
            sweep_reg  <= '0;
            filler_reg <= FILLER_RESET;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            pv_reg    <= pv_next;
            sweep_reg <= sweep_next;
            if (cfg.valid && cfg.ready)
            begin
                filler_reg <= cfg.filler_letter;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        done_reg <= done_next;
    end

endmodule

>>> sv/playfair_encryptor_top.sv
// top level of the streaming playfair encryptor
// depends on pf_pkg, the channel interfaces, pf_ctrl, pf_ram and pf_obuf
//
// usage:
//   cmd carries func and ch: key start, key bytes, key done, text bytes and
//   message end. cipher returns letters, two per pair, last_of_pair on the
//   second and message_done on the second letter of the padded final pair.
//   cfg writes the filler letter (reset 'X'); it is always ready.
// sequencing:
//   key start, key byte, non-letter or holding text byte: accepted in idle.
//   key done: the completion sweep walks all 26 letters through the grid
//   and position rams, one letter per cycle.
//   a text byte or message end that completes a pair: a position ram read,
//   a grid ram read, then the pair moves to the output buffer, where its
//   first letter becomes visible.
// stalls: the output buffer holds one pair; while it is still occupied the
//   next pair waits in the sequencer and cmd.ready stays low.
// reset: clears the key state and the held letter; the grid and position
//   rams hold garbage until a key is loaded, with no clearing pass.
module playfair_encryptor_top (
    input  logic        clk,
    input  logic        rst_n,
    pf_cmd_if.sink      cmd,
    pf_cipher_if.source cipher,
    pf_cfg_if.sink      cfg
);
    import pf_pkg::*;

    mem_wr_t mem_wr;
    logic    pos_re;
    letter_t pos_ra0, pos_ra1;
    cell_t   pos_rd0, pos_rd1;
    logic    grid_re;
    cell_t   grid_ra0, grid_ra1;
    letter_t grid_rd0, grid_rd1;
    pair_t   pair;
    logic    push;
    logic    can_push;

    pf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .cfg      (cfg),
        .mem_wr   (mem_wr),
        .pos_re   (pos_re),
        .pos_ra0  (pos_ra0),
        .pos_ra1  (pos_ra1),
        .pos_rd0  (pos_rd0),
        .pos_rd1  (pos_rd1),
        .grid_re  (grid_re),
        .grid_ra0 (grid_ra0),
        .grid_ra1 (grid_ra1),
        .grid_rd0 (grid_rd0),
        .grid_rd1 (grid_rd1),
        .pair     (pair),
        .push     (push),
        .can_push (can_push)
    );

    // letter -> grid position
    pf_ram #(.WIDTH(5), .DEPTH(LETTER_COUNT)) u_pos_ram (
        .clk    (clk),
        .we     (mem_wr.en),
        .waddr  (mem_wr.letter),
        .wdata  (mem_wr.slot),
        .re     (pos_re),
        .raddr0 (pos_ra0),
        .raddr1 (pos_ra1),
        .rdata0 (pos_rd0),
        .rdata1 (pos_rd1)
    );

    // grid position -> letter
    pf_ram #(.WIDTH(5), .DEPTH(GRID_CELLS)) u_grid_ram (
        .clk    (clk),
        .we     (mem_wr.en),
        .waddr  (mem_wr.slot),
        .wdata  (mem_wr.letter),
        .re     (grid_re),
        .raddr0 (grid_ra0),
        .raddr1 (grid_ra1),
        .rdata0 (grid_rd0),
        .rdata1 (grid_rd1)
    );

    pf_obuf u_obuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .pair     (pair),
        .push     (push),
        .can_push (can_push),
        .cipher   (cipher)
    );

    // a position lookup is always followed by the grid read
    a_lookup_chain: assert property (@(posedge clk) disable iff (!rst_n)
        pos_re |=> grid_re)
        else $error("grid read did not follow position lookup");

    // key writes never overlap a cipher lookup
    a_no_wr_on_rd: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr.en |-> !(pos_re || grid_re))
        else $error("ram write during lookup");

    // the first letter of a pair is always followed by its second letter
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        cipher.valid && cipher.ready && !cipher.last_of_pair |=>
            cipher.valid && cipher.last_of_pair)
        else $error("second letter of pair missing");

endmodule
